// ===== hdl/cspc_pkg.sv =====
// ----------------------------------------------------------------------------
// cspc_pkg: shared types and constants of the cruise speed controller
// Field widths, command and status codes, register indexes, sequencer states.
// ----------------------------------------------------------------------------
package cspc_pkg;

	// field and datapath widths
	localparam int GAIN_W     = 32;
	localparam int RPM_W      = 14;
	localparam int PERIOD_W   = 16;
	localparam int STEP_W     = 17;
	localparam int TIME_W     = 32;
	localparam int SPEED_W    = 8;
	localparam int PEDAL_W    = 18;
	localparam int Q_W        = 17;
	localparam int ERR_W      = 9;
	localparam int DIFF_W     = 10;
	localparam int INTEG_W    = 48;
	localparam int DERIV_W    = 26;
	localparam int QUO_W      = 25;
	localparam int MUL_A_W    = 48;
	localparam int MUL_B_W    = 32;
	localparam int PROD_W     = MUL_A_W + MUL_B_W;
	localparam int ACC_W      = 64;
	localparam int MODE_W     = 3;
	localparam int STATUS_W   = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int IN_DATA_W  = 80;
	localparam int OUT_DATA_W = 32;

	// fixed-point constants
	localparam logic [Q_W-1:0]     Q_ONE        = 17'd65536;
	localparam logic [Q_W-1:0]     PEDAL_THRESH = 17'd655;
	localparam logic [ACC_W-2:0]   SAT_MAG      = 63'h4000_0000_0000_0000;

	// register reset values
	localparam logic [GAIN_W-1:0]   GAIN_P_RST    = 32'd6554;
	localparam logic [GAIN_W-1:0]   GAIN_I_RST    = 32'd7;
	localparam logic [GAIN_W-1:0]   GAIN_D_RST    = 32'd0;
	localparam logic [RPM_W-1:0]    RPM_LIMIT_RST = 14'd6000;
	localparam logic [PERIOD_W-1:0] PERIOD_RST    = 16'd100;
	localparam logic [STEP_W-1:0]   STEP_RST      = 17'd655;

	typedef enum logic [MODE_W-1:0] {
		MODE_TICK     = 3'd0,
		MODE_ENABLE   = 3'd1,
		MODE_DISABLE  = 3'd2,
		MODE_REENABLE = 3'd3,
		MODE_INC      = 3'd4,
		MODE_DEC      = 3'd5
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_NONE  = 2'd0,
		STAT_SPEED = 2'd1,
		STAT_PEDAL = 2'd2
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_P    = 3'd0,
		REG_GAIN_I    = 3'd1,
		REG_GAIN_D    = 3'd2,
		REG_RPM_LIMIT = 3'd3,
		REG_PERIOD    = 3'd4,
		REG_STEP      = 3'd5
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INTEG,
		ST_DERIV,
		ST_PTERM,
		ST_ITERM,
		ST_DTERM,
		ST_DONE
	} state_t;

endpackage

// ===== hdl/cruise_speed_pid_controller.sv =====
// Commands other than a PID tick give their result in the cycle after acceptance.
// A tick that runs the PID makes four passes through the shared shift-add
// multiplier, one through the serial divider (skipped when no time has elapsed)
// and a closing state.
// Throughput: one command at a time; s_tready stays low while the PID runs and
// while a result waits in the output register.
// Reset: arst_n clears all controller state and loads the register defaults.
// ----------------------------------------------------------------------------
// cruise_speed_pid_controller: cruise control command processor
// Applies disable rules, pedal sampling, target/pedal steps and a Q16 PID
// with clamping and anti-windup, sequenced over a shared multiplier.
// ----------------------------------------------------------------------------
module cruise_speed_pid_controller (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// now_ms[31:0] speed[39:32] rpm[53:40] braking[54] car_link[55]
	// pedal_link[56] pedal_position[74:57]
	input  logic [cspc_pkg::IN_DATA_W-1:0]       s_tdata,
	// mode[2:0]
	input  logic [cspc_pkg::MODE_W-1:0]          s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// pedal_write[0] virtual_pedal[17:1] is_enabled[18] is_speed_mode[19]
	// target_speed[27:20] status[29:28]
	output logic [cspc_pkg::OUT_DATA_W-1:0]      m_tdata,
	input  logic                                 cfg_wr_en,
	input  logic [cspc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [cspc_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

	localparam int QW = cspc_pkg::Q_W;

	// configuration registers
	logic signed [cspc_pkg::GAIN_W-1:0] gain_p_q, gain_i_q, gain_d_q;
	logic [cspc_pkg::RPM_W-1:0]         rpm_limit_q;
	logic [cspc_pkg::PERIOD_W-1:0]      period_q;
	logic [cspc_pkg::STEP_W-1:0]        step_q;

	// controller state
	logic                               engaged_q, need_sample_q, speed_mode_q, link_seen_q;
	logic [cspc_pkg::SPEED_W-1:0]       target_q, saved_target_q;
	logic [QW-1:0]                      control_q, control_base_q;
	logic signed [cspc_pkg::ERR_W-1:0]  prev_error_q;
	logic signed [cspc_pkg::INTEG_W-1:0] prev_integral_q;
	logic [cspc_pkg::TIME_W-1:0]        last_time_q;

	// PID work registers
	logic signed [cspc_pkg::ERR_W-1:0]   err_q;
	logic signed [cspc_pkg::DIFF_W-1:0]  diff_q;
	logic [cspc_pkg::TIME_W-1:0]         dt_q;
	logic signed [cspc_pkg::PEDAL_W-1:0] pedal_q;
	logic signed [cspc_pkg::INTEG_W-1:0] integ_q;
	logic signed [cspc_pkg::DERIV_W-1:0] deriv_q;
	logic signed [cspc_pkg::ACC_W-1:0]   acc_q;

	cspc_pkg::state_t state_q, state_d;
	logic             launch_q;

	logic                              m_tvalid_q;
	logic [cspc_pkg::OUT_DATA_W-1:0]   m_tdata_q;

	// input fields
	logic [cspc_pkg::TIME_W-1:0]         in_now;
	logic [cspc_pkg::SPEED_W-1:0]        in_speed;
	logic [cspc_pkg::RPM_W-1:0]          in_rpm;
	logic                                in_brk, in_link, in_plink;
	logic signed [cspc_pkg::PEDAL_W-1:0] in_pedal;
	logic                                accept;

	assign in_now   = s_tdata[31:0];
	assign in_speed = s_tdata[39:32];
	assign in_rpm   = s_tdata[53:40];
	assign in_brk   = s_tdata[54];
	assign in_link  = s_tdata[55];
	assign in_plink = s_tdata[56];
	assign in_pedal = s_tdata[74:57];

	assign s_tready = (state_q == cspc_pkg::ST_IDLE) && !m_tvalid_q;
	assign accept   = s_tvalid && s_tready;

	// ------------------------------------------------------------------
	// command decode: next state of the controller for one request
	// ------------------------------------------------------------------
	logic                          nx_engaged, nx_need, nx_sm, nx_link_seen;
	logic [cspc_pkg::SPEED_W-1:0]  nx_target, nx_saved;
	logic [QW-1:0]                 nx_control, nx_base;
	logic                          nx_clear_pid;
	logic [cspc_pkg::TIME_W-1:0]   nx_last_time;
	logic                          pid_go;
	logic                          res_wr;
	logic [QW-1:0]                 res_vp;
	cspc_pkg::status_t             res_status;
	logic [cspc_pkg::TIME_W-1:0]   dt_in;
	logic [QW:0]                   up_sum;

	assign dt_in  = in_now - last_time_q;
	assign up_sum = {1'b0, control_q} + {1'b0, step_q};

	always_comb begin
		nx_engaged   = engaged_q;
		nx_need      = need_sample_q;
		nx_sm        = speed_mode_q;
		nx_link_seen = link_seen_q;
		nx_target    = target_q;
		nx_saved     = saved_target_q;
		nx_control   = control_q;
		nx_base      = control_base_q;
		nx_clear_pid = 1'b0;
		nx_last_time = last_time_q;
		pid_go       = 1'b0;
		res_wr       = 1'b0;
		res_vp       = '0;
		res_status   = cspc_pkg::STAT_NONE;
		case (cspc_pkg::mode_t'(s_tuser))
			cspc_pkg::MODE_TICK: begin
				// disable rules
				if (!in_plink || (in_link ? (in_brk || in_rpm > rpm_limit_q) : link_seen_q)) begin
					if (engaged_q)
						nx_saved = target_q;
					nx_engaged = 1'b0;
					nx_target  = '0;
					nx_sm      = 1'b0;
				end
				nx_link_seen = in_link;
				// one pedal sample after enable
				if (nx_engaged && need_sample_q) begin
					nx_need = 1'b0;
					if (in_pedal[cspc_pkg::PEDAL_W-1]) begin
						nx_saved   = nx_target;
						nx_engaged = 1'b0;
						nx_target  = '0;
						nx_sm      = 1'b0;
						nx_control = '0;
					end else if (in_pedal[QW-1:0] > cspc_pkg::Q_ONE) begin
						nx_control = cspc_pkg::Q_ONE;
					end else begin
						nx_control = in_pedal[QW-1:0];
					end
					nx_base = nx_control;
				end
				if (!nx_engaged) begin
					nx_clear_pid = 1'b1;
					nx_last_time = '0;
				end else if (nx_sm && dt_in >= {16'd0, period_q}) begin
					pid_go       = 1'b1;
					nx_last_time = in_now;
				end
			end
			cspc_pkg::MODE_ENABLE, cspc_pkg::MODE_REENABLE: begin
				nx_engaged = 1'b1;
				nx_need    = 1'b1;
				nx_sm      = in_link;
				nx_target  = (cspc_pkg::mode_t'(s_tuser) == cspc_pkg::MODE_REENABLE)
					? saved_target_q : in_speed;
				res_status = in_link ? cspc_pkg::STAT_SPEED : cspc_pkg::STAT_PEDAL;
			end
			cspc_pkg::MODE_DISABLE: begin
				if (engaged_q)
					nx_saved = target_q;
				nx_engaged = 1'b0;
				nx_target  = '0;
				nx_sm      = 1'b0;
			end
			cspc_pkg::MODE_INC: begin
				if (speed_mode_q) begin
					if (target_q != '1)
						nx_target = target_q + 1'b1;
				end else begin
					nx_control = (up_sum > {1'b0, cspc_pkg::Q_ONE}) ? cspc_pkg::Q_ONE
						: up_sum[QW-1:0];
					res_wr = 1'b1;
					res_vp = nx_control;
				end
			end
			cspc_pkg::MODE_DEC: begin
				if (speed_mode_q) begin
					nx_target = (target_q <= 8'd1) ? '0 : target_q - 1'b1;
				end else begin
					nx_control = (control_q < step_q) ? '0 : control_q - step_q;
					res_wr = 1'b1;
					res_vp = nx_control;
				end
			end
			default: begin
			end
		endcase
	end

	// ------------------------------------------------------------------
	// shared arithmetic units
	// ------------------------------------------------------------------
	logic                          mul_start, mul_done, div_start, div_done;
	logic [cspc_pkg::MUL_A_W-1:0]  mul_a;
	logic [cspc_pkg::MUL_B_W-1:0]  mul_b;
	logic [cspc_pkg::PROD_W-1:0]   mul_p;
	logic [cspc_pkg::QUO_W-1:0]    div_q;
	logic [cspc_pkg::QUO_W-1:0]    div_n;

	cspc_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.p      (mul_p),
		.done   (mul_done)
	);

	cspc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.n      (div_n),
		.d      (dt_q),
		.q      (div_q),
		.done   (div_done)
	);

	// operand magnitudes
	logic [cspc_pkg::ERR_W-1:0]    err_mag;
	logic [cspc_pkg::DIFF_W-1:0]   diff_mag;
	logic [cspc_pkg::INTEG_W-1:0]  integ_mag;
	logic [cspc_pkg::DERIV_W-1:0]  deriv_mag;

	assign err_mag   = err_q[cspc_pkg::ERR_W-1] ? -err_q : err_q;
	assign diff_mag  = diff_q[cspc_pkg::DIFF_W-1] ? -diff_q : diff_q;
	assign integ_mag = integ_q[cspc_pkg::INTEG_W-1] ? -integ_q : integ_q;
	assign deriv_mag = deriv_q[cspc_pkg::DERIV_W-1] ? -deriv_q : deriv_q;
	assign div_n     = {diff_mag[8:0], 16'd0};

	function automatic logic [cspc_pkg::GAIN_W-1:0] gmag(
		input logic signed [cspc_pkg::GAIN_W-1:0] g);
		gmag = g[cspc_pkg::GAIN_W-1] ? -g : g;
	endfunction

	// ------------------------------------------------------------------
	// sequencer: next state
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			cspc_pkg::ST_IDLE:  if (accept && pid_go) state_d = cspc_pkg::ST_INTEG;
			cspc_pkg::ST_INTEG: if (mul_done)
				state_d = (dt_q != '0) ? cspc_pkg::ST_DERIV : cspc_pkg::ST_PTERM;
			cspc_pkg::ST_DERIV: if (div_done) state_d = cspc_pkg::ST_PTERM;
			cspc_pkg::ST_PTERM: if (mul_done) state_d = cspc_pkg::ST_ITERM;
			cspc_pkg::ST_ITERM: if (mul_done) state_d = cspc_pkg::ST_DTERM;
			cspc_pkg::ST_DTERM: if (mul_done) state_d = cspc_pkg::ST_DONE;
			cspc_pkg::ST_DONE:  state_d = cspc_pkg::ST_IDLE;
			default:            state_d = cspc_pkg::ST_IDLE;
		endcase
	end

	// ------------------------------------------------------------------
	// sequencer: unit operands and start pulses
	// ------------------------------------------------------------------
	logic term_neg;

	always_comb begin
		mul_start = 1'b0;
		div_start = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		term_neg  = 1'b0;
		case (state_q)
			cspc_pkg::ST_INTEG: begin
				mul_start = launch_q;
				mul_a     = {39'd0, err_mag};
				mul_b     = dt_q;
				term_neg  = err_q[cspc_pkg::ERR_W-1];
			end
			cspc_pkg::ST_DERIV: begin
				div_start = launch_q;
			end
			cspc_pkg::ST_PTERM: begin
				mul_start = launch_q;
				mul_a     = {39'd0, err_mag};
				mul_b     = gmag(gain_p_q);
				term_neg  = gain_p_q[cspc_pkg::GAIN_W-1] ^ err_q[cspc_pkg::ERR_W-1];
			end
			cspc_pkg::ST_ITERM: begin
				mul_start = launch_q;
				mul_a     = integ_mag;
				mul_b     = gmag(gain_i_q);
				term_neg  = gain_i_q[cspc_pkg::GAIN_W-1] ^ integ_q[cspc_pkg::INTEG_W-1];
			end
			cspc_pkg::ST_DTERM: begin
				mul_start = launch_q;
				mul_a     = {22'd0, deriv_mag};
				mul_b     = gmag(gain_d_q);
				term_neg  = gain_d_q[cspc_pkg::GAIN_W-1] ^ deriv_q[cspc_pkg::DERIV_W-1];
			end
			default: begin
			end
		endcase
	end

	// ------------------------------------------------------------------
	// term shaping: saturate the product, apply sign, accumulate
	// ------------------------------------------------------------------
	logic [cspc_pkg::PROD_W-1:0]       prod_sh;
	logic [cspc_pkg::ACC_W-2:0]        term_mag;
	logic signed [cspc_pkg::ACC_W-1:0] term;
	logic signed [cspc_pkg::ACC_W-1:0] acc_in;
	logic signed [cspc_pkg::ACC_W:0]   acc_sum;
	logic signed [cspc_pkg::ACC_W-1:0] acc_sat;
	logic signed [cspc_pkg::INTEG_W:0] integ_sum;
	logic signed [cspc_pkg::INTEG_W-1:0] integ_sat;

	always_comb begin
		prod_sh  = (state_q == cspc_pkg::ST_DTERM) ? (mul_p >> 16) : mul_p;
		term_mag = (prod_sh > {17'd0, cspc_pkg::SAT_MAG}) ? cspc_pkg::SAT_MAG
			: prod_sh[cspc_pkg::ACC_W-2:0];
		term     = term_neg ? -$signed({1'b0, term_mag}) : $signed({1'b0, term_mag});
		acc_in   = (state_q == cspc_pkg::ST_PTERM)
			? $signed({47'd0, control_base_q}) : acc_q;
		acc_sum  = {acc_in[cspc_pkg::ACC_W-1], acc_in} + {term[cspc_pkg::ACC_W-1], term};
		if (acc_sum > $signed({2'b00, cspc_pkg::SAT_MAG}))
			acc_sat = $signed({1'b0, cspc_pkg::SAT_MAG});
		else if (acc_sum < -$signed({2'b00, cspc_pkg::SAT_MAG}))
			acc_sat = -$signed({1'b0, cspc_pkg::SAT_MAG});
		else
			acc_sat = acc_sum[cspc_pkg::ACC_W-1:0];
		// integral sum with 48-bit saturation
		integ_sum = {prev_integral_q[cspc_pkg::INTEG_W-1], prev_integral_q}
			+ term[cspc_pkg::INTEG_W:0];
		if (integ_sum[cspc_pkg::INTEG_W] != integ_sum[cspc_pkg::INTEG_W-1])
			integ_sat = integ_sum[cspc_pkg::INTEG_W]
				? {1'b1, {(cspc_pkg::INTEG_W-1){1'b0}}}
				: {1'b0, {(cspc_pkg::INTEG_W-1){1'b1}}};
		else
			integ_sat = integ_sum[cspc_pkg::INTEG_W-1:0];
	end

	// ------------------------------------------------------------------
	// final clamp and pedal override
	// ------------------------------------------------------------------
	logic [QW-1:0]      pid_out;
	logic               pid_clamped;
	logic [QW+1:0]      ovr_sum;
	logic [QW-1:0]      ovr_vp;
	logic               override;

	always_comb begin
		pid_clamped = 1'b1;
		if (acc_q >= $signed({47'd0, cspc_pkg::Q_ONE}))
			pid_out = cspc_pkg::Q_ONE;
		else if (acc_q <= 0)
			pid_out = '0;
		else begin
			pid_out     = acc_q[QW-1:0];
			pid_clamped = 1'b0;
		end
		override = !pedal_q[cspc_pkg::PEDAL_W-1]
			&& (pedal_q[QW-1:0] > cspc_pkg::PEDAL_THRESH);
		ovr_sum  = {2'b00, control_q} + {1'b0, pedal_q[QW:0]};
		ovr_vp   = (ovr_sum > {2'b00, cspc_pkg::Q_ONE}) ? cspc_pkg::Q_ONE : ovr_sum[QW-1:0];
	end

	// ------------------------------------------------------------------
	// sequencer state
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= cspc_pkg::ST_IDLE;
			launch_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			launch_q <= (state_d != state_q);
		end
	end

	// ------------------------------------------------------------------
	// configuration writes
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q    <= cspc_pkg::GAIN_P_RST;
			gain_i_q    <= cspc_pkg::GAIN_I_RST;
			gain_d_q    <= cspc_pkg::GAIN_D_RST;
			rpm_limit_q <= cspc_pkg::RPM_LIMIT_RST;
			period_q    <= cspc_pkg::PERIOD_RST;
			step_q      <= cspc_pkg::STEP_RST;
		end else if (cfg_wr_en) begin
			case (cspc_pkg::reg_idx_t'(cfg_index))
				cspc_pkg::REG_GAIN_P:    gain_p_q    <= cfg_wdata;
				cspc_pkg::REG_GAIN_I:    gain_i_q    <= cfg_wdata;
				cspc_pkg::REG_GAIN_D:    gain_d_q    <= cfg_wdata;
				cspc_pkg::REG_RPM_LIMIT: rpm_limit_q <= cfg_wdata[cspc_pkg::RPM_W-1:0];
				cspc_pkg::REG_PERIOD:    period_q    <= cfg_wdata[cspc_pkg::PERIOD_W-1:0];
				cspc_pkg::REG_STEP:      step_q      <= cfg_wdata[cspc_pkg::STEP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// controller state: commit decoded request, then PID results
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			engaged_q       <= 1'b0;
			need_sample_q   <= 1'b0;
			speed_mode_q    <= 1'b0;
			link_seen_q     <= 1'b0;
			target_q        <= '0;
			saved_target_q  <= '0;
			control_q       <= '0;
			control_base_q  <= '0;
			prev_error_q    <= '0;
			prev_integral_q <= '0;
			last_time_q     <= '0;
		end else if (accept) begin
			engaged_q      <= nx_engaged;
			need_sample_q  <= nx_need;
			speed_mode_q   <= nx_sm;
			link_seen_q    <= nx_link_seen;
			target_q       <= nx_target;
			saved_target_q <= nx_saved;
			control_q      <= nx_control;
			control_base_q <= nx_base;
			last_time_q    <= nx_last_time;
			if (nx_clear_pid) begin
				prev_error_q    <= '0;
				prev_integral_q <= '0;
			end
		end else if (state_q == cspc_pkg::ST_DONE) begin
			prev_error_q <= err_q;
			if (!pid_clamped)
				prev_integral_q <= integ_q;
			if (!override)
				control_q <= pid_out;
		end
	end

	// ------------------------------------------------------------------
	// PID work registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (accept) begin
			err_q   <= $signed({1'b0, nx_target}) - $signed({1'b0, in_speed});
			diff_q  <= $signed({2'b00, nx_target}) - $signed({2'b00, in_speed})
				- {prev_error_q[cspc_pkg::ERR_W-1], prev_error_q};
			dt_q    <= dt_in;
			pedal_q <= in_pedal;
			deriv_q <= '0;
		end
		if (state_q == cspc_pkg::ST_INTEG && mul_done)
			integ_q <= integ_sat;
		if (state_q == cspc_pkg::ST_DERIV && div_done)
			deriv_q <= diff_q[cspc_pkg::DIFF_W-1]
				? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
		if (mul_done && (state_q == cspc_pkg::ST_PTERM || state_q == cspc_pkg::ST_ITERM
			|| state_q == cspc_pkg::ST_DTERM))
			acc_q <= acc_sat;
	end

	// ------------------------------------------------------------------
	// result register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if ((accept && !pid_go) || state_q == cspc_pkg::ST_DONE) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !pid_go) begin
			m_tdata_q <= {2'b00, res_status, nx_target, nx_sm, nx_engaged, res_vp, res_wr};
		end else if (state_q == cspc_pkg::ST_DONE) begin
			m_tdata_q <= {2'b00, cspc_pkg::STAT_NONE, target_q, speed_mode_q, engaged_q,
				(override ? ovr_vp : pid_out), 1'b1};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// ------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------
	a_busy_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != cspc_pkg::ST_IDLE |-> !m_tvalid_q)
		else $error("result pending while PID sequence runs");

	a_mul_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == cspc_pkg::ST_INTEG || state_q == cspc_pkg::ST_PTERM
			|| state_q == cspc_pkg::ST_ITERM || state_q == cspc_pkg::ST_DTERM))
		else $error("multiplier finished outside a multiply step");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == cspc_pkg::ST_DERIV)
		else $error("divider finished outside the derivative step");

	a_mode_needs_engage: assert property (@(posedge clk) disable iff (!arst_n)
		!engaged_q |-> !speed_mode_q)
		else $error("speed mode active while disengaged");

	a_control_range: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> control_q <= cspc_pkg::Q_ONE)
		else $error("pedal control out of range");

endmodule

// ===== hdl/cspc_mul.sv =====
// ----------------------------------------------------------------------------
// cspc_mul: shift-add magnitude multiplier
// One bit of the B operand per cycle; product held until the next start.
// ----------------------------------------------------------------------------
module cspc_mul (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [cspc_pkg::MUL_A_W-1:0]        a,
	input  logic [cspc_pkg::MUL_B_W-1:0]        b,
	output logic [cspc_pkg::PROD_W-1:0]         p,
	output logic                                done
);

	localparam int CNT_W = $clog2(cspc_pkg::MUL_B_W);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(cspc_pkg::MUL_B_W - 1);

	logic [cspc_pkg::MUL_A_W-1:0] a_q;
	logic [cspc_pkg::PROD_W-1:0]  p_q;
	logic [cspc_pkg::MUL_A_W:0]   sum;
	logic [CNT_W-1:0]             cnt_q;
	logic                         busy_q;
	logic                         done_q;

	// add A into the upper half when the current multiplier bit is set
	assign sum = {1'b0, p_q[cspc_pkg::PROD_W-1:cspc_pkg::MUL_B_W]}
		+ (p_q[0] ? {1'b0, a_q} : '0);

	// sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= '0;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == LAST) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// partial product shift
	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			p_q <= {{cspc_pkg::MUL_A_W{1'b0}}, b};
		end else if (busy_q) begin
			p_q <= {sum, p_q[cspc_pkg::MUL_B_W-1:1]};
		end
	end

	assign p    = p_q;
	assign done = done_q;

endmodule

// ===== hdl/cspc_div.sv =====
// ----------------------------------------------------------------------------
// cspc_div: restoring magnitude divider
// One quotient bit per cycle; quotient held until the next start.
// ----------------------------------------------------------------------------
module cspc_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [cspc_pkg::QUO_W-1:0]        n,
	input  logic [cspc_pkg::TIME_W-1:0]       d,
	output logic [cspc_pkg::QUO_W-1:0]        q,
	output logic                              done
);

	localparam int CNT_W = $clog2(cspc_pkg::QUO_W);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(cspc_pkg::QUO_W - 1);

	logic [cspc_pkg::QUO_W-1:0]  n_q;
	logic [cspc_pkg::TIME_W-1:0] d_q;
	logic [cspc_pkg::TIME_W-1:0] rem_q;
	logic [cspc_pkg::TIME_W:0]   r_sh;
	logic [cspc_pkg::TIME_W:0]   r_sub;
	logic                        ge;
	logic [CNT_W-1:0]            cnt_q;
	logic                        busy_q;
	logic                        done_q;

	// trial subtract of the shifted remainder
	assign r_sh  = {rem_q, n_q[cspc_pkg::QUO_W-1]};
	assign r_sub = r_sh - {1'b0, d_q};
	assign ge    = r_sh >= {1'b0, d_q};

	// sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= '0;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == LAST) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// shift dividend out, quotient bits in
	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= n;
			d_q   <= d;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? r_sub[cspc_pkg::TIME_W-1:0] : r_sh[cspc_pkg::TIME_W-1:0];
			n_q   <= {n_q[cspc_pkg::QUO_W-2:0], ge};
		end
	end

	assign q    = n_q;
	assign done = done_q;

endmodule
